@@ hdl/sbe_pkg.sv @@
// Package for the stack bytecode executor: opcodes, status codes, memory size and
// the command/status structs between the controller and the datapath. No dependencies.
package sbe_pkg;

  // Data memory depth in 32-bit words.
  localparam int MEM_WORDS = 16384;

  typedef enum logic [5:0] {
    OP_LEA = 6'd0, OP_IMM = 6'd1, OP_JMP = 6'd2, OP_JSR = 6'd3, OP_BZ = 6'd4,
    OP_BNZ = 6'd5, OP_ENT = 6'd6, OP_ADJ = 6'd7, OP_LEV = 6'd8, OP_LI = 6'd9,
    OP_LC = 6'd10, OP_SI = 6'd11, OP_SC = 6'd12, OP_PSH = 6'd13, OP_OR = 6'd14,
    OP_XOR = 6'd15, OP_AND = 6'd16, OP_EQ = 6'd17, OP_NE = 6'd18, OP_LT = 6'd19,
    OP_GT = 6'd20, OP_LE = 6'd21, OP_GE = 6'd22, OP_SHL = 6'd23, OP_SHR = 6'd24,
    OP_ADD = 6'd25, OP_SUB = 6'd26, OP_MUL = 6'd27, OP_DIV = 6'd28, OP_MOD = 6'd29,
    OP_OPEN = 6'd30, OP_MCMP = 6'd36, OP_EXIT = 6'd37
  } opcode_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EXITED  = 3'd1;
  localparam logic [2:0] ST_SYSCALL = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;

  localparam logic CFG_ENTRY = 1'b0;
  localparam logic CFG_STACK = 1'b1;

  // Memory address select.
  typedef enum logic [2:0] {
    MA_SP, MA_ACC, MA_POP, MA_FP, MA_FP4
  } maddr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   mem_rd;     // issue read at selected address
    maddr_t rd_sel;
    logic   pop_a;      // latch read data into operand register A
    logic   pop_b;      // latch read data into operand register B
    logic   exec;       // perform the instruction's register updates/write
    logic   div_start;
    logic   finish;     // load the result registers
  } sbe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
  } sbe_sts_t;

endpackage

@@ hdl/sbe_divider.sv @@
// Radix-2 restoring signed divider for DIV and MOD, one quotient bit per cycle.
// Depends on nothing outside this file.
module sbe_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  logic [5:0]  cnt_r;
  logic [31:0] q_r, d_r;
  logic [32:0] rem_r;
  logic        negq_r, negr_r;
  logic [32:0] trial;
  logic [31:0] absn, absd;

  assign absn  = dividend[31] ? (~dividend + 32'd1) : dividend;
  assign absd  = divisor[31] ? (~divisor + 32'd1) : divisor;
  assign trial = {rem_r[31:0], q_r[31]} - {1'b0, d_r};
  assign busy  = (cnt_r != 6'd0);
  assign quotient  = negq_r ? (~q_r + 32'd1) : q_r;
  assign remainder = negr_r ? (~rem_r[31:0] + 32'd1) : rem_r[31:0];

  // Shift-subtract iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else if (start) begin
      cnt_r  <= 6'd32;
      q_r    <= absn;
      d_r    <= absd;
      rem_r  <= 33'd0;
      negq_r <= dividend[31] ^ divisor[31];
      negr_r <= dividend[31];
    end else if (busy) begin
      cnt_r <= cnt_r - 6'd1;
      if (!trial[32]) begin
        rem_r <= trial;
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], q_r[31]};
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end
endmodule

@@ hdl/sbe_datapath.sv @@
// Datapath: architectural registers, data memory, ALU and result registers.
// Depends on sbe_pkg and sbe_divider.
module sbe_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  sbe_pkg::sbe_cmd_t cmd,
  output sbe_pkg::sbe_sts_t sts,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             in_operation,
  input  logic [5:0]       in_opcode,
  input  logic [31:0]      in_operand_word,
  input  logic [15:0]      in_preload_address,
  output logic [15:0]      out_next_fetch_address,
  output logic [31:0]      out_accumulator_value,
  output logic [2:0]       out_status,
  output logic [31:0]      out_exit_value
);
  import sbe_pkg::*;
  localparam int AW = $clog2(MEM_WORDS);

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rdata_r, a_r, b_r;
  logic [31:0] acc_r, acc_nxt;
  logic [15:0] pc_r, pc_nxt, sp_r, sp_nxt, fp_r, fp_nxt;
  logic        halted_r, fresh_r;
  logic [2:0]  hstat_r, stat_nxt;
  logic [31:0] hexit_r, exv_nxt;
  logic [15:0] raddr, waddr;
  logic [31:0] wdata;
  logic        we;
  logic        div_busy;
  logic [31:0] quo, rem;
  logic [15:0] ofs, pc1, pc2;
  logic [4:0]  sh;
  logic [31:0] sa_b;

  sbe_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(a_r), .divisor(acc_r),
    .busy(div_busy), .quotient(quo), .remainder(rem)
  );
  assign sts.div_busy = div_busy;

  // Read address select; the popped address comes straight from the last read.
  always_comb begin
    case (cmd.rd_sel)
      MA_SP:   raddr = sp_r;
      MA_ACC:  raddr = acc_r[15:0];
      MA_POP:  raddr = rdata_r[15:0];
      MA_FP:   raddr = fp_r;
      MA_FP4:  raddr = fp_r + 16'd4;
      default: raddr = sp_r;
    endcase
  end

  // Data memory, read data registered.
  always_ff @(posedge clk) begin
    if (we) mem[waddr[AW+1:2]] <= wdata;
    if (cmd.mem_rd) rdata_r <= mem[raddr[AW+1:2]];
  end

  assign ofs = {in_operand_word[13:0], 2'b00};
  assign pc1 = pc_r + 16'd4;
  assign pc2 = pc_r + 16'd8;
  assign sh  = acc_r[4:0];
  assign sa_b = {24'd0, acc_r[7:0]} << {a_r[1:0], 3'b000};

  // Instruction execution.
  always_comb begin
    acc_nxt = acc_r; pc_nxt = pc_r; sp_nxt = sp_r; fp_nxt = fp_r;
    stat_nxt = ST_OK; exv_nxt = 32'd0;
    we = 1'b0; waddr = sp_r; wdata = acc_r;
    if (in_operation) begin
      we = cmd.exec; waddr = in_preload_address; wdata = in_operand_word;
    end else if (!halted_r) begin
      case (in_opcode) inside
        OP_LEA: begin acc_nxt = {16'd0, fp_r + ofs}; pc_nxt = pc2; end
        OP_IMM: begin acc_nxt = in_operand_word; pc_nxt = pc2; end
        OP_JMP: pc_nxt = in_operand_word[15:0];
        OP_JSR: begin
          sp_nxt = sp_r - 16'd4; we = cmd.exec; waddr = sp_nxt; wdata = {16'd0, pc2};
          pc_nxt = in_operand_word[15:0];
        end
        OP_BZ:  pc_nxt = (acc_r != 0) ? pc2 : in_operand_word[15:0];
        OP_BNZ: pc_nxt = (acc_r != 0) ? in_operand_word[15:0] : pc2;
        OP_ENT: begin
          we = cmd.exec; waddr = sp_r - 16'd4; wdata = {16'd0, fp_r};
          fp_nxt = sp_r - 16'd4; sp_nxt = sp_r - 16'd4 - ofs; pc_nxt = pc2;
        end
        OP_ADJ: begin sp_nxt = sp_r + ofs; pc_nxt = pc2; end
        OP_LEV: begin
          fp_nxt = a_r[15:0]; pc_nxt = b_r[15:0]; sp_nxt = fp_r + 16'd8;
        end
        OP_LI:  begin acc_nxt = rdata_r; pc_nxt = pc1; end
        OP_LC:  begin
          acc_nxt = {{24{rdata_r[8*acc_r[1:0]+7]}}, rdata_r[8*acc_r[1:0] +: 8]};
          pc_nxt = pc1;
        end
        OP_SI:  begin
          we = cmd.exec; waddr = a_r[15:0]; sp_nxt = sp_r + 16'd4; pc_nxt = pc1;
        end
        OP_SC:  begin
          we = cmd.exec; waddr = a_r[15:0];
          wdata = (rdata_r & ~(32'hFF << {a_r[1:0], 3'b000})) | sa_b;
          acc_nxt = {{24{acc_r[7]}}, acc_r[7:0]}; sp_nxt = sp_r + 16'd4; pc_nxt = pc1;
        end
        OP_PSH: begin
          sp_nxt = sp_r - 16'd4; we = cmd.exec; waddr = sp_nxt; pc_nxt = pc1;
        end
        [OP_OR:OP_MOD]: begin
          sp_nxt = sp_r + 16'd4; pc_nxt = pc1;
          case (in_opcode)
            OP_OR:  acc_nxt = a_r | acc_r;
            OP_XOR: acc_nxt = a_r ^ acc_r;
            OP_AND: acc_nxt = a_r & acc_r;
            OP_EQ:  acc_nxt = {31'd0, a_r == acc_r};
            OP_NE:  acc_nxt = {31'd0, a_r != acc_r};
            OP_LT:  acc_nxt = {31'd0, $signed(a_r) < $signed(acc_r)};
            OP_GT:  acc_nxt = {31'd0, $signed(a_r) > $signed(acc_r)};
            OP_LE:  acc_nxt = {31'd0, $signed(a_r) <= $signed(acc_r)};
            OP_GE:  acc_nxt = {31'd0, $signed(a_r) >= $signed(acc_r)};
            OP_SHL: acc_nxt = a_r << sh;
            OP_SHR: acc_nxt = $unsigned($signed(a_r) >>> sh);
            OP_ADD: acc_nxt = a_r + acc_r;
            OP_SUB: acc_nxt = a_r - acc_r;
            OP_MUL: acc_nxt = b_r;
            OP_DIV: if (acc_r == 0) stat_nxt = ST_DIVZERO; else acc_nxt = quo;
            default: if (acc_r == 0) stat_nxt = ST_DIVZERO; else acc_nxt = rem;
          endcase
        end
        [OP_OPEN:OP_MCMP]: begin stat_nxt = ST_SYSCALL; pc_nxt = pc1; end
        // The word at the stack pointer was latched into A by the first read.
        OP_EXIT: begin stat_nxt = ST_EXITED; exv_nxt = a_r; end
        default: stat_nxt = ST_INVALID;
      endcase
    end
  end

  // Operand registers; B also holds the registered product for MUL.
  always_ff @(posedge clk) begin
    if (cmd.pop_a) a_r <= rdata_r;
    if (cmd.pop_b) b_r <= rdata_r;
    else if (cmd.exec && in_opcode == OP_MUL) b_r <= a_r * acc_r;
  end

  // Architectural state and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0; pc_r <= 16'd0; sp_r <= 16'hFFFC; fp_r <= 16'hFFFC;
      halted_r <= 1'b0; fresh_r <= 1'b1; hstat_r <= ST_OK; hexit_r <= 32'd0;
      out_next_fetch_address <= 16'd0; out_accumulator_value <= 32'd0;
      out_status <= ST_OK; out_exit_value <= 32'd0;
    end else begin
      if (cfg_we && fresh_r) begin
        if (cfg_index == CFG_ENTRY) pc_r <= cfg_data;
        else begin sp_r <= cfg_data; fp_r <= cfg_data; end
      end
      if (cmd.finish) begin
        if (in_operation) begin
          out_status <= ST_OK; out_exit_value <= 32'd0;
          out_next_fetch_address <= pc_r; out_accumulator_value <= acc_r;
        end else if (halted_r) begin
          out_status <= hstat_r; out_exit_value <= hexit_r;
          out_next_fetch_address <= pc_r; out_accumulator_value <= acc_r;
        end else begin
          fresh_r <= 1'b0;
          acc_r <= acc_nxt; pc_r <= pc_nxt; sp_r <= sp_nxt; fp_r <= fp_nxt;
          out_next_fetch_address <= pc_nxt; out_accumulator_value <= acc_nxt;
          out_status <= stat_nxt; out_exit_value <= exv_nxt;
          if (stat_nxt == ST_EXITED || stat_nxt == ST_INVALID) begin
            halted_r <= 1'b1; hstat_r <= stat_nxt; hexit_r <= exv_nxt;
          end
        end
      end
    end
  end
endmodule

@@ hdl/sbe_control.sv @@
// Controller state machine: sequences stack reads, execution, division and result.
// Depends on sbe_pkg.
module sbe_control (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [5:0]        in_opcode,
  output logic              out_valid,
  input  logic              out_stall,
  output sbe_pkg::sbe_cmd_t cmd,
  input  sbe_pkg::sbe_sts_t sts
);
  import sbe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic   is_lev;

  // Item is held at the input (stalled) until its result is loaded.
  assign in_stall  = !(state_r == S_DONE && !(ov_r && out_stall));
  assign out_valid = ov_r;

  assign is_lev = !in_operation && in_opcode == OP_LEV;

  always_comb begin
    state_nxt = state_r; ov_nxt = ov_r;
    cmd = '0; cmd.rd_sel = MA_SP;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = is_lev ? MA_FP : MA_SP;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        // First read is the popped word (or the saved frame pointer for LEV).
        cmd.pop_a = 1'b1; cmd.mem_rd = 1'b1;
        cmd.rd_sel = is_lev ? MA_FP4 : (in_opcode == OP_SC ? MA_POP : MA_ACC);
        state_nxt = S_RD2;
      end
      S_RD2: begin
        if (is_lev) cmd.pop_b = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (!in_operation && (in_opcode == OP_DIV || in_opcode == OP_MOD)) begin
          cmd.div_start = 1'b1; state_nxt = S_DIV;
        end else state_nxt = S_DONE;
      end
      S_DIV: if (!sts.div_busy) state_nxt = S_DONE;
      default: if (!(ov_r && out_stall)) begin
        cmd.finish = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
    end
  end
endmodule

@@ hdl/stack_bytecode_executor.sv @@
// Channel | ports                                       | accept when
// in      | in_valid/in_stall, operation..preload_addr   | in_valid & !in_stall
// out     | out_valid/out_stall, four result fields      | out_valid & !out_stall
// cfg     | cfg_we, cfg_index, cfg_data                  | cfg_we
// An item steps through two stack/memory reads, a state for the second read's
// data, execute and result load; DIV and MOD also wait on the bit-serial divider.
// A single-port-read memory sets the read sequence. Reset is synchronous, active low.
// The input stays stalled until the item's result is loaded into the output register.
module stack_bytecode_executor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [5:0]  in_opcode,
  input  logic signed [31:0] in_operand_word,
  input  logic [15:0] in_preload_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_next_fetch_address,
  output logic signed [31:0] out_accumulator_value,
  output logic [2:0]  out_status,
  output logic signed [31:0] out_exit_value,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import sbe_pkg::*;
  sbe_cmd_t cmd;
  sbe_sts_t sts;

  sbe_control u_ctl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_opcode(in_opcode), .out_valid(out_valid),
    .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  sbe_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_operation(in_operation),
    .in_opcode(in_opcode), .in_operand_word(in_operand_word),
    .in_preload_address(in_preload_address),
    .out_next_fetch_address(out_next_fetch_address),
    .out_accumulator_value(out_accumulator_value), .out_status(out_status),
    .out_exit_value(out_exit_value)
  );
endmodule

@@ hdl/sbe_checker.sv @@
// Port-level checker for stack_bytecode_executor, bound to the top level.
// Depends on sbe_pkg.
module sbe_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_exit_value
);
  import sbe_pkg::*;

  // A held result's status must not change while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result changed under stall");

  // An input transaction is followed by a result in the next cycle.
  a_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("no result after input transaction");

  // Exit value is zero unless exited.
  a_exit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_EXITED |-> out_exit_value == 32'd0)
    else $error("exit value without exit");

  // Status stays within defined codes.
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_DIVZERO)
    else $error("undefined status");
endmodule

bind stack_bytecode_executor sbe_port_checker u_sbe_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_exit_value(out_exit_value)
);

@@ sim/sbe_checker.sv @@
// Scoreboard for the stack bytecode executor: watches the input, result and
// register-write ports, predicts every result and compares it. Depends on sbe_pkg.
module sbe_checker
  import sbe_pkg::*;
#(
  parameter int MEM_WORDS = 16384
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_operation,
  input  logic [5:0]           in_opcode,
  input  logic [31:0]          in_operand_word,
  input  logic [15:0]          in_preload_address,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [15:0]          out_next_fetch_address,
  input  logic [31:0]          out_accumulator_value,
  input  logic [2:0]           out_status,
  input  logic [31:0]          out_exit_value,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   errors,
  output int                   pending,
  output logic [31:0]          vm_acc,
  output logic [15:0]          vm_sp,
  output logic [15:0]          vm_fp,
  output logic [31:0]          stack_word,
  output logic [MEM_WORDS-1:0] written
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] pc;
    logic [31:0] acc;
    logic [2:0]  status;
    logic [31:0] exv;
  } step_result_t;

  step_result_t result_q[$];
  logic [31:0]  mem[MEM_WORDS];
  logic [15:0]  pc, entry_reg, stack_reg;
  logic         halted, fresh;
  logic [2:0]   held_status;
  logic [31:0]  held_exit;

  assign stack_word = mem[(vm_sp >> 2) % MEM_WORDS];

  function automatic int widx(logic [15:0] ad);
    return (ad >> 2) % MEM_WORDS;
  endfunction

  function automatic logic [31:0] sext8(logic [31:0] v);
    return {{24{v[7]}}, v[7:0]};
  endfunction

  task automatic push_w(logic [31:0] v);
    vm_sp = vm_sp - 16'd4;
    mem[widx(vm_sp)] = v;
    written[widx(vm_sp)] = 1'b1;
  endtask

  task automatic pop_w(output logic [31:0] v);
    v = mem[widx(vm_sp)];
    vm_sp = vm_sp + 16'd4;
  endtask

  // Executes one accepted transaction against the shadow machine.
  task automatic execute_step(logic oper, logic [5:0] opc, logic [31:0] w,
                              logic [15:0] pa);
    logic [31:0] a, b, old, exv;
    logic [15:0] ofs, pc1, pc2, ad;
    logic [2:0]  st;
    int          sh;
    longint      qv;
    step_result_t r;
    st = ST_OK;
    exv = '0;
    if (oper) begin
      mem[widx(pa)] = w;
      written[widx(pa)] = 1'b1;
    end else if (halted) begin
      st = held_status;
      exv = held_exit;
    end else begin
      fresh = 1'b0;
      ofs = w[13:0] << 2;
      pc1 = pc + 16'd4;
      pc2 = pc + 16'd8;
      b = vm_acc;
      case (opc)
        OP_LEA: begin vm_acc = {16'd0, vm_fp + ofs}; pc = pc2; end
        OP_IMM: begin vm_acc = w; pc = pc2; end
        OP_JMP: pc = w[15:0];
        OP_JSR: begin push_w({16'd0, pc2}); pc = w[15:0]; end
        OP_BZ:  pc = (b != 0) ? pc2 : w[15:0];
        OP_BNZ: pc = (b != 0) ? w[15:0] : pc2;
        OP_ENT: begin
          push_w({16'd0, vm_fp});
          vm_fp = vm_sp;
          vm_sp = vm_sp - ofs;
          pc = pc2;
        end
        OP_ADJ: begin vm_sp = vm_sp + ofs; pc = pc2; end
        OP_LEV: begin
          vm_sp = vm_fp;
          pop_w(a);
          vm_fp = a[15:0];
          pop_w(a);
          pc = a[15:0];
        end
        OP_LI: begin vm_acc = mem[widx(b[15:0])]; pc = pc1; end
        OP_LC: begin
          vm_acc = sext8(mem[widx(b[15:0])] >> (8 * b[1:0]));
          pc = pc1;
        end
        OP_SI: begin
          pop_w(a);
          mem[widx(a[15:0])] = b;
          written[widx(a[15:0])] = 1'b1;
          pc = pc1;
        end
        OP_SC: begin
          pop_w(a);
          ad = a[15:0];
          sh = 8 * ad[1:0];
          old = mem[widx(ad)];
          mem[widx(ad)] = (old & ~(32'hFF << sh)) | ({24'd0, b[7:0]} << sh);
          written[widx(ad)] = 1'b1;
          vm_acc = sext8(b);
          pc = pc1;
        end
        OP_PSH: begin push_w(b); pc = pc1; end
        default: begin
          if (opc >= OP_OR && opc <= OP_MOD) begin
            pop_w(a);
            case (opc)
              OP_OR:  vm_acc = a | b;
              OP_XOR: vm_acc = a ^ b;
              OP_AND: vm_acc = a & b;
              OP_EQ:  vm_acc = {31'd0, a == b};
              OP_NE:  vm_acc = {31'd0, a != b};
              OP_LT:  vm_acc = {31'd0, $signed(a) < $signed(b)};
              OP_GT:  vm_acc = {31'd0, $signed(a) > $signed(b)};
              OP_LE:  vm_acc = {31'd0, $signed(a) <= $signed(b)};
              OP_GE:  vm_acc = {31'd0, $signed(a) >= $signed(b)};
              OP_SHL: vm_acc = a << b[4:0];
              OP_SHR: vm_acc = $signed(a) >>> b[4:0];
              OP_ADD: vm_acc = a + b;
              OP_SUB: vm_acc = a - b;
              OP_MUL: vm_acc = a * b;
              default: begin
                // Division by zero keeps the accumulator and only flags it.
                if (b == 0) begin
                  st = ST_DIVZERO;
                end else begin
                  if (opc == OP_DIV)
                    qv = longint'($signed(a)) / longint'($signed(b));
                  else
                    qv = longint'($signed(a)) % longint'($signed(b));
                  vm_acc = qv[31:0];
                end
              end
            endcase
            pc = pc1;
          end else if (opc >= OP_OPEN && opc <= OP_MCMP) begin
            st = ST_SYSCALL;
            pc = pc1;
          end else if (opc == OP_EXIT) begin
            exv = mem[widx(vm_sp)];
            st = ST_EXITED;
            halted = 1'b1;
          end else begin
            st = ST_INVALID;
            halted = 1'b1;
          end
        end
      endcase
      if (halted) begin
        held_status = st;
        held_exit = exv;
      end
    end
    r.pc = pc;
    r.acc = vm_acc;
    r.status = st;
    r.exv = exv;
    result_q.push_back(r);
  endtask

  // Compares one result transaction with the oldest prediction.
  task automatic compare_result();
    step_result_t e;
    if (result_q.size() == 0) begin
      $error("result transaction with no prediction waiting");
      errors++;
      return;
    end
    e = result_q.pop_front();
    if (out_next_fetch_address !== e.pc) begin
      $error("next_fetch_address: expected %h, got %h", e.pc, out_next_fetch_address);
      errors++;
    end
    if (out_accumulator_value !== e.acc) begin
      $error("accumulator_value: expected %h, got %h", e.acc, out_accumulator_value);
      errors++;
    end
    if (out_status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, out_status);
      errors++;
    end
    if (out_exit_value !== e.exv) begin
      $error("exit_value: expected %h, got %h", e.exv, out_exit_value);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    written = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      entry_reg = 16'd0;
      stack_reg = 16'd65532;
      vm_acc = '0;
      pc = 16'd0;
      vm_sp = 16'd65532;
      vm_fp = 16'd65532;
      halted = 1'b0;
      fresh = 1'b1;
      held_status = ST_OK;
      held_exit = '0;
      result_q.delete();
    end else begin
      // Register writes load the pointers only before the first instruction.
      if (cfg_we) begin
        if (cfg_index == CFG_ENTRY) begin
          entry_reg = cfg_data;
          if (fresh) pc = cfg_data;
        end else begin
          stack_reg = cfg_data;
          if (fresh) begin
            vm_sp = cfg_data;
            vm_fp = cfg_data;
          end
        end
      end
      if (in_valid && !in_stall)
        execute_step(in_operation, in_opcode, in_operand_word, in_preload_address);
      if (out_valid && !out_stall)
        compare_result();
    end
    pending = result_q.size();
  end

  final begin
    if (result_q.size() != 0)
      $display("%0d predicted results never arrived", result_q.size());
  end
endmodule

@@ sim/testbench.sv @@
// Stack bytecode executor testbench top: clock, reset, stimulus with random
// gaps and stalls, verdict. Depends on sbe_pkg, the executor and sbe_checker.
module testbench;
  import sbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_operation;
  logic [5:0]  in_opcode;
  logic [31:0] in_operand_word;
  logic [15:0] in_preload_address;
  logic        out_valid, out_stall;
  logic [15:0] out_next_fetch_address;
  logic [31:0] out_accumulator_value, out_exit_value;
  logic [2:0]  out_status;
  logic        cfg_we, cfg_index;
  logic [15:0] cfg_data;

  int          errors, pending, burst_left, idle_cycles, stall_left, stall_mode;
  logic [31:0] vm_acc, stack_word;
  logic [15:0] vm_sp, vm_fp;
  logic [MEM_WORDS-1:0] written;

  stack_bytecode_executor u_top (.*);

  sbe_checker #(.MEM_WORDS(MEM_WORDS)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls in stretches: none, random, mostly stalled or alternating.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(5, 60);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 1);
        2: out_stall <= (stall_left % 12) < 9;
        default: out_stall <= stall_left[0];
      endcase
    end
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("** stack_bytecode_executor: FAILED **");
      $finish;
    end
  end

  function automatic logic word_ready(logic [15:0] ad);
    return written[(ad >> 2) % MEM_WORDS];
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  // Drives one transaction, opening a new burst after a random gap when due.
  task automatic send(logic oper, logic [5:0] opc, logic [31:0] w, logic [15:0] pa);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_operation <= oper;
    in_opcode <= opc;
    in_operand_word <= w;
    in_preload_address <= pa;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic preload(logic [15:0] ad, logic [31:0] d);
    send(1'b1, OP_LEA, d, ad);
  endtask

  // Issues an instruction after preloading any memory word it would read.
  task automatic exec_op(logic [5:0] opc, logic [31:0] w = 32'h0);
    logic [15:0] need;
    logic        missing;
    forever begin
      missing = 1'b0;
      case (opc)
        OP_LEV: begin
          if (!word_ready(vm_fp)) begin missing = 1'b1; need = vm_fp; end
          else if (!word_ready(vm_fp + 16'd4)) begin
            missing = 1'b1;
            need = vm_fp + 16'd4;
          end
        end
        OP_LI, OP_LC:
          if (!word_ready(vm_acc[15:0])) begin missing = 1'b1; need = vm_acc[15:0]; end
        OP_SC: begin
          if (!word_ready(vm_sp)) begin missing = 1'b1; need = vm_sp; end
          else if (!word_ready(stack_word[15:0])) begin
            missing = 1'b1;
            need = stack_word[15:0];
          end
        end
        default:
          if ((opc >= OP_SI && opc <= OP_SI) || (opc >= OP_OR && opc <= OP_MOD) ||
              opc == OP_EXIT)
            if (!word_ready(vm_sp)) begin missing = 1'b1; need = vm_sp; end
      endcase
      if (!missing) break;
      preload(need, ($urandom_range(0, 1) == 0) ? {16'd0, 16'($urandom)} : pick_word());
    end
    send(1'b0, opc, w, 16'($urandom));
  endtask

  // Registers are written only with the block idle and nothing outstanding.
  task automatic write_reg(logic idx, logic [15:0] d);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    burst_left = 0;
  endtask

  task automatic random_chunk(int count);
    logic [5:0]  opc;
    logic [31:0] w;
    for (int i = 0; i < count; i++) begin
      opc = 6'($urandom_range(0, OP_EXIT - 1));
      w = pick_word();
      if (opc == OP_ENT || opc == OP_ADJ)
        w = $urandom_range(0, 16) - 8;
      else if (opc == OP_IMM && $urandom_range(0, 1) == 0)
        w = {16'd0, vm_sp + 16'($urandom_range(0, 32) - 16)};
      if ($urandom_range(0, 9) == 0)
        preload(16'($urandom), $urandom);
      exec_op(opc, w);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_opcode = OP_LEA;
    in_operand_word = '0;
    in_preload_address = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ENTRY;
    cfg_data = '0;
    burst_left = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Before the first instruction the registers also load the pointers.
    write_reg(CFG_ENTRY, 16'hFFFF);
    write_reg(CFG_STACK, 16'h0000);
    write_reg(CFG_STACK, 16'hFFFC);

    // Directed part: overflow and zero divisors, branches, calls, shifts, syscalls, bytes.
    exec_op(OP_IMM, 32'h8000_0000);
    exec_op(OP_PSH);
    exec_op(OP_IMM, 32'hFFFF_FFFF);
    exec_op(OP_DIV);
    exec_op(OP_PSH);
    exec_op(OP_IMM, 32'hFFFF_FFFF);
    exec_op(OP_MOD);
    exec_op(OP_PSH);
    exec_op(OP_DIV);
    exec_op(OP_PSH);
    exec_op(OP_MOD);
    exec_op(OP_BZ, 32'h0000_1234);
    exec_op(OP_BNZ, 32'hFFFF_0040);
    exec_op(OP_LEA, 32'h7FFF_FFFF);
    exec_op(OP_LC);
    exec_op(OP_JSR, 32'h0000_0100);
    exec_op(OP_ENT, 32'h2);
    exec_op(OP_IMM, 32'h8000_0001);
    exec_op(OP_PSH);
    exec_op(OP_IMM, 32'd31);
    exec_op(OP_SHR);
    exec_op(OP_LEV);
    exec_op(OP_OPEN);
    exec_op(OP_MCMP);
    exec_op(OP_SC);

    random_chunk(110);
    write_reg(CFG_ENTRY, 16'h0000);
    random_chunk(50);
    // Hold off until every outstanding result has come back.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    burst_left = 0;
    random_chunk(60);
    write_reg(CFG_STACK, 16'($urandom));
    random_chunk(110);

    // Halt the machine, then show that it holds while preloads still work.
    if ($urandom_range(0, 1) == 0)
      exec_op(OP_EXIT);
    else
      exec_op(6'($urandom_range(OP_EXIT + 1, 63)));
    exec_op(OP_IMM, 32'h5);
    preload(16'($urandom), $urandom);
    exec_op(6'($urandom_range(0, 63)));

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("** stack_bytecode_executor: PASSED **");
    else
      $display("** stack_bytecode_executor: FAILED **");
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/sbe_pkg.sv
hdl/sbe_divider.sv
hdl/sbe_datapath.sv
hdl/sbe_control.sv
hdl/stack_bytecode_executor.sv
hdl/sbe_checker.sv
sim/sbe_checker.sv
sim/testbench.sv
